### design/numeric_text_value_parser_defines.svh
// ----------------------------------------------------------------------------
// Numeric text value parser: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_TEXT_VALUE_PARSER_DEFINES_SVH
`define NUMERIC_TEXT_VALUE_PARSER_DEFINES_SVH

// Same-cycle implication: whenever cond holds, prop must hold.
`define NTVP_ASSERT_IMP(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("ntvp: same-cycle check failed");

// Next-cycle implication: whenever cond holds, prop must hold in the next cycle.
`define NTVP_ASSERT_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("ntvp: next-cycle check failed");

`endif

### design/ntvp_pkg.sv
// ----------------------------------------------------------------------------
// Numeric text value parser package
// Character classes, value kinds, status codes and limits shared by the
// front end, the queue and the parsing back end.
// ----------------------------------------------------------------------------
package ntvp_pkg;

   // Value kinds, as carried on req_func.
   localparam logic [1:0] KIND_I32  = 2'd0;
   localparam logic [1:0] KIND_U32  = 2'd1;
   localparam logic [1:0] KIND_U64  = 2'd2;
   localparam logic [1:0] KIND_IPV4 = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // Byte counts reported on success.
   localparam logic [3:0] BYTES_WORD  = 4'd4;
   localparam logic [3:0] BYTES_DWORD = 4'd8;
   localparam logic [3:0] BYTES_NONE  = 4'd0;

   // Magnitude limits and their tenths, for the multiply-add overflow check.
   localparam logic [63:0] LIM_I32_POS   = 64'd2147483647;
   localparam logic [63:0] LIM_I32_NEG   = 64'd2147483648;
   localparam logic [63:0] LIM_U32       = 64'hFFFF_FFFF;
   localparam logic [63:0] LIM_U64       = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_I32_DIV10 = 64'd214748364;
   localparam logic [63:0] LIM_U32_DIV10 = 64'd429496729;
   localparam logic [63:0] LIM_U64_DIV10 = 64'd1844674407370955161;
   localparam logic [11:0] OCTET_MAX     = 12'd255;
   localparam logic [1:0]  OCTET_DIGITS  = 2'd3;
   localparam logic [1:0]  LAST_OCTET    = 2'd3;

   // Character classes decided by the front end.
   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_BLANK,
      CLS_DIGIT,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DOT,
      CLS_OTHER
   } char_class_type;

   // One classified item as it travels through the queue.
   typedef struct packed {
      logic [1:0]     kind;
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } entry_type;

endpackage

### design/ntvp_front.sv
// ----------------------------------------------------------------------------
// Numeric text value parser: front end
// Accepts items from the request channel and classifies each character.
// ----------------------------------------------------------------------------
module ntvp_front
   import ntvp_pkg::*;
(
   input  logic       req_valid,
   input  logic [1:0] req_func,
   input  logic       req_has_char,
   input  logic [7:0] req_char_code,
   input  logic       req_last,
   input  logic       queue_full,
   output logic       req_stall,
   output logic       push,
   output entry_type  push_entry
);

   logic [7:0] digit_off;

   // The queue is the only place an item can wait.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign digit_off = req_char_code - 8'd48;

   // Character classification.
   always_comb begin
      push_entry.kind  = req_func;
      push_entry.last  = req_last;
      push_entry.digit = digit_off[3:0];
      if (!req_has_char) begin
         push_entry.cls = CLS_NONE;
      end else if (req_char_code == 8'd32 ||
                   (req_char_code >= 8'd9 && req_char_code <= 8'd13)) begin
         push_entry.cls = CLS_BLANK;
      end else if (req_char_code >= 8'd48 && req_char_code <= 8'd57) begin
         push_entry.cls = CLS_DIGIT;
      end else if (req_char_code == 8'd43) begin
         push_entry.cls = CLS_PLUS;
      end else if (req_char_code == 8'd45) begin
         push_entry.cls = CLS_MINUS;
      end else if (req_char_code == 8'd46) begin
         push_entry.cls = CLS_DOT;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end

endmodule

### design/ntvp_queue.sv
// ----------------------------------------------------------------------------
// Numeric text value parser: item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "numeric_text_value_parser_defines.svh"

module ntvp_queue
   import ntvp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slots_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slots_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `NTVP_ASSERT_IMP(a_pop_needs_item, pop, count_ff != 2'd0)
   `NTVP_ASSERT_IMP(a_ptrs_track_count, count_ff == 2'd0 || count_ff == 2'd2,
                    wr_ptr_ff == rd_ptr_ff)

endmodule

### design/ntvp_back.sv
// ----------------------------------------------------------------------------
// Numeric text value parser: back end
// Runs the parse state machine on classified items and holds the result.
// ----------------------------------------------------------------------------
`include "numeric_text_value_parser_defines.svh"

module ntvp_back
   import ntvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  entry_type   q_head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_parsed_value,
   output logic [3:0]  rsp_byte_count,
   output logic [1:0]  rsp_status
);

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_DOT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] acc_ff, acc_in;
   logic [8:0]  oct_ff, oct_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [1:0]  idx_ff, idx_in;
   logic        neg_ff, neg_in;
   logic [1:0]  err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] value_ff, value_in;
   logic [3:0]  count_ff, count_in;
   logic [1:0]  status_ff, status_in;

   logic [1:0]  kind_eff;
   logic [63:0] lim;
   logic [63:0] lim_div10;
   logic [67:0] acc_next;
   logic [11:0] oct_next;
   logic [1:0]  dig_err;

   // An item moves on only when the result register has room.
   assign pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = value_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_status       = status_ff;

   // The kind is latched from the first item of a text.
   assign kind_eff = (phase_ff == PH_START) ? q_head.kind : kind_ff;

   // Limits of the current kind.
   always_comb begin
      unique case (kind_eff)
         KIND_I32: begin
            lim       = neg_ff ? LIM_I32_NEG : LIM_I32_POS;
            lim_div10 = LIM_I32_DIV10;
         end
         KIND_U32: begin
            lim       = LIM_U32;
            lim_div10 = LIM_U32_DIV10;
         end
         default: begin
            lim       = LIM_U64;
            lim_div10 = LIM_U64_DIV10;
         end
      endcase
   end

   // Multiply by ten and add the digit, with its range checks.
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                     {64'd0, q_head.digit};
   assign oct_next = ({3'd0, oct_ff} << 3) + ({3'd0, oct_ff} << 1) +
                     {8'd0, q_head.digit};

   always_comb begin
      dig_err = ST_OK;
      if (kind_eff == KIND_IPV4) begin
         if (dcnt_ff >= OCTET_DIGITS) begin
            dig_err = ST_INVALID;
         end else if (oct_next > OCTET_MAX) begin
            dig_err = ST_OVERFLOW;
         end
      end else if (acc_ff > lim_div10 || acc_next > {4'd0, lim}) begin
         dig_err = ST_OVERFLOW;
      end
   end

   // Parse step for one item, and the result on the last one.
   always_comb begin
      logic digit_take;
      logic done;
      logic [63:0] packed_acc;

      phase_in     = phase_ff;
      kind_in      = kind_ff;
      acc_in       = acc_ff;
      oct_in       = oct_ff;
      dcnt_in      = dcnt_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      digit_take   = 1'b0;
      done         = 1'b0;
      packed_acc   = acc_ff;

      if (pop) begin
         if (phase_ff == PH_START) begin
            kind_in  = q_head.kind;
            phase_in = PH_LEAD;
         end

         // Character handling while no error is latched.
         if (q_head.cls != CLS_NONE && err_ff == ST_OK) begin
            unique case (phase_in)
               PH_LEAD: begin
                  if (q_head.cls == CLS_DIGIT) begin
                     phase_in   = PH_DIGITS;
                     digit_take = 1'b1;
                  end else if (kind_in == KIND_I32 &&
                               (q_head.cls == CLS_PLUS || q_head.cls == CLS_MINUS)) begin
                     neg_in   = (q_head.cls == CLS_MINUS);
                     phase_in = PH_SIGN;
                  end else if (q_head.cls != CLS_BLANK) begin
                     err_in = ST_INVALID;
                  end
               end
               PH_SIGN: begin
                  if (q_head.cls == CLS_DIGIT) begin
                     phase_in   = PH_DIGITS;
                     digit_take = 1'b1;
                  end else if (q_head.cls != CLS_BLANK) begin
                     err_in = ST_INVALID;
                  end
               end
               PH_DIGITS: begin
                  if (q_head.cls == CLS_DIGIT) begin
                     digit_take = 1'b1;
                  end else if (q_head.cls == CLS_BLANK) begin
                     if (kind_in == KIND_IPV4 && idx_ff != LAST_OCTET) begin
                        err_in = ST_INVALID;
                     end else begin
                        phase_in = PH_TRAIL;
                     end
                  end else if (q_head.cls == CLS_DOT && kind_in == KIND_IPV4 &&
                               idx_ff != LAST_OCTET) begin
                     acc_in   = acc_ff | ({56'd0, oct_ff[7:0]} << {idx_ff, 3'b000});
                     idx_in   = idx_ff + 2'd1;
                     oct_in   = 9'd0;
                     dcnt_in  = 2'd0;
                     phase_in = PH_DOT;
                  end else begin
                     err_in = ST_INVALID;
                  end
               end
               PH_TRAIL: begin
                  if (q_head.cls != CLS_BLANK) begin
                     err_in = ST_INVALID;
                  end
               end
               PH_DOT: begin
                  if (q_head.cls == CLS_DIGIT) begin
                     phase_in   = PH_DIGITS;
                     digit_take = 1'b1;
                  end else begin
                     err_in = ST_INVALID;
                  end
               end
               default: begin
                  err_in = ST_INVALID;
               end
            endcase

            // Digit accumulation into the octet or the full value.
            if (digit_take) begin
               if (dig_err != ST_OK) begin
                  err_in = dig_err;
               end else if (kind_in == KIND_IPV4) begin
                  oct_in  = oct_next[8:0];
                  dcnt_in = dcnt_ff + 2'd1;
               end else begin
                  acc_in = acc_next[63:0];
               end
            end
         end

         // End of text: form the result and return to the start state.
         if (q_head.last) begin
            done = (phase_in == PH_DIGITS || phase_in == PH_TRAIL) &&
                   (kind_in != KIND_IPV4 || idx_in == LAST_OCTET);
            if (err_in == ST_OK && !done) begin
               err_in = ST_INVALID;
            end
            packed_acc = acc_in | ({56'd0, oct_in[7:0]} << {idx_in, 3'b000});
            value_in   = 64'd0;
            count_in   = BYTES_NONE;
            status_in  = err_in;
            if (err_in == ST_OK) begin
               if (kind_in == KIND_IPV4) begin
                  value_in = packed_acc;
                  count_in = BYTES_WORD;
               end else if (kind_in == KIND_U64) begin
                  value_in = acc_in;
                  count_in = BYTES_DWORD;
               end else if (kind_in == KIND_I32 && neg_in) begin
                  value_in = {32'd0, 32'd0 - acc_in[31:0]};
                  count_in = BYTES_WORD;
               end else begin
                  value_in = {32'd0, acc_in[31:0]};
                  count_in = BYTES_WORD;
               end
            end
            rsp_valid_in = 1'b1;
            phase_in     = PH_START;
            kind_in      = KIND_I32;
            acc_in       = 64'd0;
            oct_in       = 9'd0;
            dcnt_in      = 2'd0;
            idx_in       = 2'd0;
            neg_in       = 1'b0;
            err_in       = ST_OK;
         end
      end
   end

   // Parse state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         kind_ff      <= KIND_I32;
         acc_ff       <= 64'd0;
         oct_ff       <= 9'd0;
         dcnt_ff      <= 2'd0;
         idx_ff       <= 2'd0;
         neg_ff       <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         acc_ff       <= acc_in;
         oct_ff       <= oct_in;
         dcnt_ff      <= dcnt_in;
         idx_ff       <= idx_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff  <= value_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   `NTVP_ASSERT_IMP(a_error_gives_empty, rsp_valid_ff && status_ff != ST_OK,
                    count_ff == BYTES_NONE && value_ff == 64'd0)
   `NTVP_ASSERT_NEXT(a_last_restarts, pop && q_head.last,
                     phase_ff == PH_START && err_ff == ST_OK && rsp_valid_ff)

endmodule

### design/numeric_text_value_parser.sv
// Flow: an accepted character is written into the queue and parsed when the back end pops it;
// the result of a last character is then registered onto rsp_*. Throughput: one character
// per cycle while no stalled result holds the back end; the parse step (multiply by ten, add,
// and a limit compare) sits in one stage of the back end. A two-entry queue decouples.
// Reset: synchronous, active high; clears the queue, parse state and rsp_valid.
// ----------------------------------------------------------------------------
// Numeric text value parser
// Parses a character stream as i32, u32, u64 or a dotted IPv4 address.
// ----------------------------------------------------------------------------
module numeric_text_value_parser
   import ntvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic        req_has_char,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_parsed_value,
   output logic [3:0]  rsp_byte_count,
   output logic [1:0]  rsp_status
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_not_empty;
   entry_type q_head;

   // Front end: accept and classify.
   ntvp_front u_front (
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_has_char  (req_has_char),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Queue between the two halves.
   ntvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back end: parse and deliver.
   ntvp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_status       (rsp_status)
   );

endmodule

### bench/numeric_text_value_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric text value parser testbench
// Streams i32, u32, u64 and dotted-quad texts into the parser at most one
// character per item under random sender gaps and receiver stalls. A scoreboard
// predicts the result of every finished text and compares each field.
// ----------------------------------------------------------------------------
module numeric_text_value_parser_test;
   import ntvp_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned RANDOM_ITEMS  = 950;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned MAX_PRINTED   = 20;

   // Character codes the parser treats specially.
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   typedef enum logic [2:0] {
      AT_START,
      IN_LEAD,
      AFTER_SIGN,
      IN_DIGITS,
      IN_TRAIL,
      AFTER_DOT
   } parse_phase_type;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_BLOCKS
   } rx_flow_type;

   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  count;
      logic [1:0]  status;
   } parse_result_type;

   typedef logic [7:0] text_type[$];

   // Tracks the parse of the text in flight and holds the results still owed.
   class text_value_scoreboard;
      parse_phase_type  phase;
      logic [1:0]       kind;
      logic [63:0]      acc;
      logic [8:0]       octet;
      logic [1:0]       digits;
      logic [1:0]       octet_idx;
      logic             negative;
      logic [1:0]       err;
      parse_result_type expected_values[$];
      int unsigned      mismatches;
      int unsigned      results_checked;
      int unsigned      status_seen[4];

      function new();
         clear_state();
         mismatches      = 0;
         results_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void clear_state();
         phase     = AT_START;
         kind      = KIND_I32;
         acc       = '0;
         octet     = '0;
         digits    = '0;
         octet_idx = '0;
         negative  = 1'b0;
         err       = ST_OK;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      // Only the first error of a text survives.
      function void latch_error(logic [1:0] code);
         if (err == ST_OK) err = code;
      endfunction

      function logic [63:0] magnitude_limit();
         if (kind == KIND_I32) return negative ? LIM_I32_NEG : LIM_I32_POS;
         if (kind == KIND_U32) return LIM_U32;
         return LIM_U64;
      endfunction

      // Multiply-add one digit, flagging the digit that passes the limit.
      function void accumulate_digit(logic [7:0] c);
         logic [63:0] d;
         logic [63:0] lim;
         d = 64'(c - CH_ZERO);
         if (kind == KIND_IPV4) begin
            if (digits == OCTET_DIGITS) begin
               latch_error(ST_INVALID);
               return;
            end
            if (64'(octet) > 64'(OCTET_MAX) / 10 ||
                64'(octet) * 10 > 64'(OCTET_MAX) - d) begin
               latch_error(ST_OVERFLOW);
               return;
            end
            octet  = 9'(octet * 10 + d[8:0]);
            digits = digits + 1'b1;
         end else begin
            lim = magnitude_limit();
            if (acc > lim / 10) begin
               latch_error(ST_OVERFLOW);
               return;
            end
            acc = acc * 10;
            if (acc > lim - d) begin
               latch_error(ST_OVERFLOW);
               return;
            end
            acc = acc + d;
         end
      endfunction

      function void commit_octet();
         acc = acc | (64'(octet[7:0]) << (8 * octet_idx));
      endfunction

      function void feed(logic [7:0] c);
         case (phase)
            IN_LEAD: begin
               if (is_digit(c)) begin
                  phase = IN_DIGITS;
                  accumulate_digit(c);
               end else if (kind == KIND_I32 && (c == CH_PLUS || c == CH_MINUS)) begin
                  negative = (c == CH_MINUS);
                  phase    = AFTER_SIGN;
               end else if (!is_blank(c)) begin
                  latch_error(ST_INVALID);
               end
            end
            AFTER_SIGN: begin
               if (is_digit(c)) begin
                  phase = IN_DIGITS;
                  accumulate_digit(c);
               end else if (!is_blank(c)) begin
                  latch_error(ST_INVALID);
               end
            end
            IN_DIGITS: begin
               if (is_digit(c)) begin
                  accumulate_digit(c);
               end else if (is_blank(c)) begin
                  if (kind == KIND_IPV4 && octet_idx != LAST_OCTET) latch_error(ST_INVALID);
                  else phase = IN_TRAIL;
               end else if (c == CH_DOT && kind == KIND_IPV4 && octet_idx < LAST_OCTET) begin
                  commit_octet();
                  octet_idx = octet_idx + 1'b1;
                  octet     = '0;
                  digits    = '0;
                  phase     = AFTER_DOT;
               end else begin
                  latch_error(ST_INVALID);
               end
            end
            IN_TRAIL: begin
               if (!is_blank(c)) latch_error(ST_INVALID);
            end
            AFTER_DOT: begin
               if (is_digit(c)) begin
                  phase = IN_DIGITS;
                  accumulate_digit(c);
               end else begin
                  latch_error(ST_INVALID);
               end
            end
            default: latch_error(ST_INVALID);
         endcase
      endfunction

      // Advance the parse by one accepted item; a last item owes one result.
      function void note_char(logic [1:0] func, logic has_char, logic [7:0] code,
                              logic last);
         parse_result_type r;
         logic [63:0]      neg;
         if (phase == AT_START) begin
            kind  = func;
            phase = IN_LEAD;
         end
         if (has_char && err == ST_OK) feed(code);
         if (!last) return;
         if (err == ST_OK && !((phase == IN_DIGITS || phase == IN_TRAIL) &&
                               (kind != KIND_IPV4 || octet_idx == LAST_OCTET)))
            latch_error(ST_INVALID);
         r.value  = '0;
         r.count  = BYTES_NONE;
         r.status = err;
         if (err == ST_OK) begin
            neg = 64'd0 - acc;
            case (kind)
               KIND_IPV4: begin
                  commit_octet();
                  r.value = acc;
                  r.count = BYTES_WORD;
               end
               KIND_U64: begin
                  r.value = acc;
                  r.count = BYTES_DWORD;
               end
               default: begin
                  r.value = (kind == KIND_I32 && negative) ? {32'd0, neg[31:0]}
                                                          : {32'd0, acc[31:0]};
                  r.count = BYTES_WORD;
               end
            endcase
         end
         expected_values.push_back(r);
         clear_state();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, what);
      endtask

      // Compare one accepted result with the oldest one owed.
      task check_result(logic [63:0] value, logic [3:0] count, logic [1:0] status);
         parse_result_type want;
         results_checked++;
         if (!$isunknown(status)) status_seen[status]++;
         if (expected_values.size() == 0) begin
            report($sformatf("result %0h with no finished text pending", value));
            return;
         end
         want = expected_values.pop_front();
         if (value !== want.value)
            report($sformatf("value %0h, predicted %0h", value, want.value));
         if (count !== want.count)
            report($sformatf("byte count %0d, predicted %0d", count, want.count));
         if (status !== want.status)
            report($sformatf("status %0d, predicted %0d", status, want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = KIND_I32;
   logic        req_has_char = 1'b0;
   logic [7:0]  req_char_code = CH_NUL;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_parsed_value;
   logic [3:0]  rsp_byte_count;
   logic [1:0]  rsp_status;

   text_value_scoreboard parse_board;
   int unsigned          cycles = 0;
   int unsigned          items_sent = 0;
   int unsigned          texts_sent = 0;
   int unsigned          burst_left = 0;
   int unsigned          flow_left = 0;
   rx_flow_type          flow_mode = FLOW_FREE;

   numeric_text_value_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_has_char     (req_has_char),
      .req_char_code    (req_char_code),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_status       (rsp_status)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with results still owed.", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Check accepted results and stall the result side in changing patterns.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         parse_board.check_result(rsp_parsed_value, rsp_byte_count, rsp_status);
      if (flow_left == 0) begin
         flow_mode = rx_flow_type'($urandom_range(0, 3));
         flow_left = $urandom_range(50, 300);
      end
      flow_left = flow_left - 1;
      case (flow_mode)
         FLOW_FREE:  rsp_stall <= 1'b0;
         FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= ((cycles % 24) < 16);
      endcase
   end

   // Offer one item, in bursts with random gaps, and wait until it is taken.
   task automatic send_char(logic [1:0] func, logic has_char, logic [7:0] code,
                            logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_valid     <= 1'b1;
      req_func      <= func;
      req_has_char  <= has_char;
      req_char_code <= code;
      req_last      <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_board.note_char(func, has_char, code, last);
      items_sent++;
   endtask

   // Hold the sender off until every owed result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (parse_board.expected_values.size() != 0) @(posedge clock);
   endtask

   // Send a whole text; later items carry a random kind, which must be ignored.
   task automatic send_text(logic [1:0] kind, text_type t);
      int unsigned i;
      bit          first;
      bit          close_empty;
      first = 1'b1;
      texts_sent++;
      if (t.size() == 0) begin
         send_char(kind, 1'b0, 8'($urandom), 1'b1);
         return;
      end
      close_empty = ($urandom_range(0, 29) == 0);
      for (i = 0; i < t.size(); i++) begin
         if ($urandom_range(0, 24) == 0) begin
            send_char(first ? kind : 2'($urandom), 1'b0, 8'($urandom), 1'b0);
            first = 1'b0;
         end
         send_char(first ? kind : 2'($urandom), 1'b1, t[i],
                   !close_empty && i == t.size() - 1);
         first = 1'b0;
      end
      if (close_empty) send_char(2'($urandom), 1'b0, 8'($urandom), 1'b1);
   endtask

   function automatic void append_text(ref text_type t, input string s);
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_blank();
      return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic void append_blanks(ref text_type t);
      int unsigned n;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) t.push_back(pick_blank());
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 7))
         0, 1:    return 8'($urandom_range(CH_ZERO, CH_NINE));
         2:       return pick_blank();
         3:       return CH_PLUS;
         4:       return CH_MINUS;
         5:       return CH_DOT;
         6:       return CH_NUL;
         default: return 8'($urandom);
      endcase
   endfunction

   // Decimal magnitude biased toward zero, the limit and just past it.
   function automatic string number_text(logic [1:0] kind, logic negative);
      logic [64:0] lim;
      logic [64:0] val;
      string       s;
      int unsigned n;
      s = "";
      if (kind == KIND_U64) lim = 65'(LIM_U64);
      else if (kind == KIND_U32) lim = 65'(LIM_U32);
      else lim = negative ? 65'(LIM_I32_NEG) : 65'(LIM_I32_POS);
      case ($urandom_range(0, 4))
         0: val = 65'($urandom_range(0, 999));
         1: val = 65'({$urandom, $urandom}) % (lim + 1);
         2: val = lim - 65'($urandom_range(0, 2));
         3: val = lim + 65'($urandom_range(1, 3));
         default: begin
            n = $urandom_range(1, 21);
            repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            return s;
         end
      endcase
      s = $sformatf("%0d", val);
      if ($urandom_range(0, 7) == 0) s = {"00", s};
      return s;
   endfunction

   function automatic string octet_text();
      case ($urandom_range(0, 9))
         0:       return $sformatf("%0d", $urandom_range(256, 999));
         1:       return $sformatf("%0d", $urandom_range(1000, 9999));
         2:       return $sformatf("0%0d", $urandom_range(0, 99));
         3:       return ($urandom_range(0, 1) == 0) ? "255" : "0";
         default: return $sformatf("%0d", $urandom_range(0, 255));
      endcase
   endfunction

   // Mostly well-formed values with random content, some broken, some noise.
   task automatic send_random_text();
      text_type    t;
      logic [1:0]  kind;
      logic        negative;
      int unsigned style;
      int unsigned pos;
      int unsigned n;
      int unsigned o;
      kind     = 2'($urandom_range(0, 3));
      style    = $urandom_range(0, 9);
      negative = 1'b0;
      if (style < 8) begin
         append_blanks(t);
         if (kind == KIND_IPV4) begin
            for (o = 0; o < 4; o++) begin
               if (o != 0) t.push_back(CH_DOT);
               append_text(t, octet_text());
            end
         end else begin
            if (kind == KIND_I32 && $urandom_range(0, 1) == 1) begin
               negative = 1'($urandom_range(0, 1));
               t.push_back(negative ? CH_MINUS : CH_PLUS);
               append_blanks(t);
            end
            append_text(t, number_text(kind, negative));
         end
         append_blanks(t);
         // Break a share of the well-formed texts.
         if (style >= 6) begin
            pos = $urandom_range(0, t.size() - 1);
            case ($urandom_range(0, 3))
               0: t[pos] = pick_noise();
               1: t.delete(pos);
               2: while (t.size() > pos) void'(t.pop_back());
               default: t.insert(pos, pick_noise());
            endcase
         end
      end else begin
         n = $urandom_range(0, 8);
         repeat (n) t.push_back(pick_noise());
      end
      send_text(kind, t);
   endtask

   task automatic send_string(logic [1:0] kind, string s);
      text_type t;
      append_text(t, s);
      send_text(kind, t);
   endtask

   initial begin
      text_type    odd_text;
      int unsigned random_start;
      bit          paused;
      paused = 1'b0;
      parse_board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts: limits, signs, dotted quads and malformed forms.
      send_string(KIND_I32, " -2147483648\t");
      send_string(KIND_I32, "2147483647");
      send_string(KIND_I32, "2147483648");
      send_string(KIND_I32, "- \n12");
      send_string(KIND_I32, "-0");
      send_string(KIND_U32, "4294967295");
      send_string(KIND_U32, "4294967296");
      send_string(KIND_U32, "+1");
      send_string(KIND_U64, "18446744073709551615 ");
      send_string(KIND_U64, "18446744073709551616");
      send_string(KIND_IPV4, "255.0.10.1");
      send_string(KIND_IPV4, "256.1.1.1");
      send_string(KIND_IPV4, "1.2.3.0004");
      send_string(KIND_IPV4, "1.2.3");
      send_string(KIND_IPV4, "1 .2.3.4");
      send_string(KIND_I32, "12x9");
      send_string(KIND_U64, "  ");
      send_text(KIND_U32, odd_text);
      odd_text.push_back(CH_NUL);
      send_text(KIND_I32, odd_text);
      wait_for_results();

      // Random texts, with one full drain halfway through.
      random_start = items_sent;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         send_random_text();
         if (!paused && items_sent >= random_start + RANDOM_ITEMS / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Parsed %0d texts from %0d characters in %0d cycles.",
               texts_sent, items_sent, cycles);
      $display("Results checked: %0d (%0d ok, %0d invalid, %0d overflow), %0d mismatches.",
               parse_board.results_checked, parse_board.status_seen[ST_OK],
               parse_board.status_seen[ST_INVALID], parse_board.status_seen[ST_OVERFLOW],
               parse_board.mismatches);
      if (parse_board.mismatches == 0 && parse_board.expected_values.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### numeric_text_value_parser.f
+incdir+design
design/ntvp_pkg.sv
design/ntvp_front.sv
design/ntvp_queue.sv
design/ntvp_back.sv
design/numeric_text_value_parser.sv
bench/numeric_text_value_parser_test.sv
